[hdl/hud_pkg.sv]
// ----------------------------------------------------------------------------
// hud_pkg
// shared sizes, constant tables and helpers of the upper sideband demodulator
// ----------------------------------------------------------------------------
package hud_pkg;

    localparam int CHAN_COUNT      = 32;
    localparam int FIR_TAPS        = 125;
    localparam int SAMPLE_BITS     = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int COEF_BITS       = 18;

    localparam int DELAY_SLOTS = (FIR_TAPS - 1) / 2 + 1;
    localparam int HALF_TAPS   = FIR_TAPS / 2;
    localparam int QUARTER     = 1 << (SINE_TABLE_BITS - 2);
    localparam int QIDX_W      = SINE_TABLE_BITS - 1;
    localparam int HIST_DEPTH  = CHAN_COUNT * FIR_TAPS;
    localparam int DELAY_DEPTH = CHAN_COUNT * DELAY_SLOTS;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
    localparam int CLR_AW      = $clog2(HIST_DEPTH > DELAY_DEPTH ? HIST_DEPTH : DELAY_DEPTH);
    localparam int CH_W        = 5;
    localparam int HPTR_W      = $clog2(FIR_TAPS + 1);
    localparam int DPTR_W      = $clog2(DELAY_SLOTS);
    localparam int ACC_W       = SAMPLE_BITS + COEF_BITS + 8;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // register indexes
    localparam logic [0:0] REG_PHASE_STEP = 1'd0;
    localparam logic [0:0] REG_GAIN       = 1'd1;

    typedef logic signed [15:0]          qs_rom_t [0:QUARTER];
    typedef logic signed [COEF_BITS-1:0] h_rom_t  [0:FIR_TAPS-1];

    // unsigned quotient by shift and subtract, used for table building
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
        longint unsigned q, rem;
        q   = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], a[i]};
            if (rem >= b)
            begin
                rem  = rem - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter wave sine, taylor series in q30, rounded to q15
    function automatic qs_rom_t build_qs();
        qs_rom_t        rom;
        longint unsigned x, x2, t;
        longint          acc, v;
        for (int r = 0; r <= QUARTER; r++)
        begin
            x   = (HALF_PI_Q30 * 64'(r)) >> (SINE_TABLE_BITS - 2);
            x2  = (x * x) >> 30;
            t   = x;
            acc = longint'(x);
            for (int n = 1; n <= 12; n++)
            begin
                t = udiv64((t * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
                if (n[0])
                    acc = acc - longint'(t);
                else
                    acc = acc + longint'(t);
            end
            if (acc < 0)
                acc = 0;
            v = longint'((64'(acc) + 64'd16384) >> 15);
            rom[r] = (v > 32767) ? 16'sd32767 : 16'(v);
        end
        return rom;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned val);
        longint unsigned v, r, b;
        v = val;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // unit energy hilbert coefficients in q1.17
    function automatic h_rom_t build_h();
        h_rom_t          rom;
        longint unsigned s, sq, ak, den, num, c;
        int              k;
        s = 0;
        for (int j = 0; j < FIR_TAPS; j++)
        begin
            k  = j - HALF_TAPS;
            ak = 64'(k < 0 ? -k : k);
            if (ak[0])
                s = s + udiv64(64'd1 << 60, ak * ak);
        end
        sq  = isqrt64(s);
        num = 64'd1 << (COEF_BITS - 1 + 30);
        for (int j = 0; j < FIR_TAPS; j++)
        begin
            k      = j - HALF_TAPS;
            ak     = 64'(k < 0 ? -k : k);
            rom[j] = '0;
            if (ak[0] && sq != 0)
            begin
                den    = ak * sq;
                c      = udiv64(num + (den >> 1), den);
                rom[j] = (k < 0) ? -COEF_BITS'(c) : COEF_BITS'(c);
            end
        end
        return rom;
    endfunction

    localparam qs_rom_t QS_ROM = build_qs();
    localparam h_rom_t  H_ROM  = build_h();

    // full wave sine from the quarter table
    function automatic logic signed [15:0] sine_at(logic [SINE_TABLE_BITS-1:0] p);
        logic [1:0]                     q;
        logic [SINE_TABLE_BITS-3:0]     r;
        logic [QIDX_W-1:0]              ri;
        logic signed [15:0]             v;
        q  = p[SINE_TABLE_BITS-1 -: 2];
        r  = p[SINE_TABLE_BITS-3:0];
        ri = q[0] ? QIDX_W'(QUARTER) - {1'b0, r} : {1'b0, r};
        v  = QS_ROM[ri];
        return q[1] ? -v : v;
    endfunction

endpackage

[hdl/hilbert_usb_demodulator.sv]
// ----------------------------------------------------------------------------
// hilbert_usb_demodulator
// per-channel mixer, 125 tap hilbert fir and delay line giving usb audio
// ----------------------------------------------------------------------------
// path: an input beat passes the mul, rnd, wr, fir, g1 and g2 states before its
//   output beat is loaded; no new beat is taken until it is through, since the single
//   mac walks the 125 taps through the one-read-port history memory; a waiting output beat
//   holds the sequencer until it is taken
// reset: control registers clear at once, then a clearing pass zeroes the history
//   and delay memories while s_tready stays low
module hilbert_usb_demodulator
    import hud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // in_phase [15:0], quadrature [31:16]
    input  logic [4:0]  s_tuser,   // chan_index
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // audio
    output logic [4:0]  m_tuser,   // out_chan
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_RND  = 4'd2;
    localparam logic [3:0] S_WR   = 4'd3;
    localparam logic [3:0] S_FIR  = 4'd4;
    localparam logic [3:0] S_G1   = 4'd5;
    localparam logic [3:0] S_G2   = 4'd6;

    logic [3:0]              state_reg, state_next;
    logic                    clr_busy_reg;
    logic [CLR_AW-1:0]       clr_cnt_reg;
    logic [31:0]             phase_step_reg;
    logic [11:0]             gain_reg;
    logic [CH_W-1:0]         ch_reg;
    logic                    last_reg;
    logic signed [15:0]      re_reg, im_reg, sa_reg, ca_reg;
    logic signed [31:0]      p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [15:0]      mre_reg, mim_reg;
    logic [HPTR_W-1:0]       hptr_reg [CHAN_COUNT];
    logic [DPTR_W-1:0]       dptr_reg [CHAN_COUNT];
    logic [31:0]             osc_reg  [CHAN_COUNT];
    logic [HPTR_W-1:0]       hidx_reg;
    logic [HPTR_W-1:0]       rd_cnt_reg;
    logic [HPTR_W-1:0]       coef_k_reg;
    logic                    pv_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0]      hist_q_reg, dly_q_reg;
    logic [29:0]             gp_lo_reg;
    logic signed [34:0]      gp_hi_reg;
    logic                    m_tvalid_reg;
    logic [15:0]             m_data_reg;
    logic [4:0]              m_user_reg;
    logic                    m_last_reg;

    logic signed [15:0]      hist_mem  [HIST_DEPTH];
    logic signed [15:0]      delay_mem [DELAY_DEPTH];

    // channel bases and pointer updates
    logic [HIST_AW-1:0]      hbase;
    logic [DELAY_AW-1:0]     dbase;
    logic [HPTR_W-1:0]       h_cur, h_nxt;
    logic [DPTR_W-1:0]       d_cur, d_nxt;
    logic [31:0]             osc_in;

    assign hbase  = HIST_AW'(ch_reg) * HIST_AW'(FIR_TAPS);
    assign dbase  = DELAY_AW'(ch_reg) * DELAY_AW'(DELAY_SLOTS);
    assign h_cur  = (hptr_reg[ch_reg] >= HPTR_W'(FIR_TAPS)) ? '0 : hptr_reg[ch_reg];
    assign h_nxt  = (h_cur + 1'b1 >= HPTR_W'(FIR_TAPS)) ? '0 : h_cur + 1'b1;
    assign d_cur  = (32'(dptr_reg[ch_reg]) >= 32'(DELAY_SLOTS)) ? '0 : dptr_reg[ch_reg];
    assign d_nxt  = (32'(d_cur) + 1 >= 32'(DELAY_SLOTS)) ? '0 : d_cur + 1'b1;
    assign osc_in = osc_reg[s_tuser];

    // mixer rounding and saturation
    logic signed [33:0] sum_re, sum_im;
    logic signed [18:0] sh_re, sh_im;
    logic signed [15:0] mix_re, mix_im;

    function automatic logic signed [15:0] sat16(logic signed [18:0] v);
        if (v > 19'sd32767)
            return 16'sh7fff;
        else if (v < -19'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    assign sum_re = 34'(p0_reg) - 34'(p1_reg) + 34'sd16384;
    assign sum_im = 34'(p2_reg) + 34'(p3_reg) + 34'sd16384;
    assign sh_re  = 19'(sum_re >>> 15);
    assign sh_im  = 19'(sum_im >>> 15);
    assign mix_re = (phase_step_reg == '0) ? re_reg : sat16(sh_re);
    assign mix_im = (phase_step_reg == '0) ? im_reg : sat16(sh_im);

    // usb difference and gain scaling
    logic signed [ACC_W-1:0] usb;
    logic signed [53:0]      prod;
    logic [53:0]             mag;
    logic [28:0]             mshift;
    logic signed [15:0]      audio;

    assign usb  = (ACC_W'(dly_q_reg) <<< (COEF_BITS - 1)) - acc_reg;
    assign prod = (54'(gp_hi_reg) <<< 18) + $signed(54'(gp_lo_reg));
    assign mag  = prod[53] ? 54'(-prod) : 54'(prod);
    assign mshift = 29'(mag >> (COEF_BITS + 7));

    always_comb
    begin
        if (prod[53])
            audio = (mshift > 29'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, mshift}));
        else
            audio = (mshift > 29'd32767) ? 16'sh7fff : mshift[15:0];
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && !clr_busy_reg;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) state_next = S_MUL;
            S_MUL:  state_next = S_RND;
            S_RND:  state_next = S_WR;
            S_WR:   state_next = S_FIR;
            S_FIR:  if (rd_cnt_reg == HPTR_W'(FIR_TAPS) && pv_reg) state_next = S_G1;
            S_G1:   state_next = S_G2;
            S_G2:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clr_busy_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            phase_step_reg <= '0;
            gain_reg       <= 12'd1280;
            m_tvalid_reg   <= 1'b0;
            pv_reg         <= 1'b0;
            rd_cnt_reg     <= '0;
            for (int i = 0; i < CHAN_COUNT; i++)
            begin
                hptr_reg[i] <= '0;
                dptr_reg[i] <= '0;
                osc_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // clearing pass over both memories
            if (clr_busy_reg)
            begin
                if (clr_cnt_reg == CLR_AW'(HIST_DEPTH - 1))
                    clr_busy_reg <= 1'b0;
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            // register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PHASE_STEP: phase_step_reg <= cfg_data;
                    REG_GAIN:       gain_reg       <= cfg_data[11:0];
                    default:        ;
                endcase
            end

            // output beat taken, unless the gain stage reloads it
            if (m_tvalid_reg && m_tready && state_reg != S_G2)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        ch_reg   <= s_tuser;
                        last_reg <= s_tlast;
                        re_reg   <= s_tdata[15:0];
                        im_reg   <= s_tdata[31:16];
                        sa_reg   <= sine_at(osc_in[31 -: SINE_TABLE_BITS]);
                        ca_reg   <= sine_at(osc_in[31 -: SINE_TABLE_BITS]
                                            + SINE_TABLE_BITS'(QUARTER));
                    end
                end
                S_MUL:
                begin
                    p0_reg <= re_reg * ca_reg;
                    p1_reg <= im_reg * sa_reg;
                    p2_reg <= re_reg * sa_reg;
                    p3_reg <= im_reg * ca_reg;
                end
                S_RND:
                begin
                    mre_reg <= mix_re;
                    mim_reg <= mix_im;
                    if (phase_step_reg != '0)
                        osc_reg[ch_reg] <= osc_reg[ch_reg] + phase_step_reg;
                end
                S_WR:
                begin
                    hptr_reg[ch_reg] <= h_nxt;
                    dptr_reg[ch_reg] <= d_nxt;
                    hidx_reg         <= h_nxt;
                    rd_cnt_reg       <= '0;
                    pv_reg           <= 1'b0;
                    acc_reg          <= '0;
                end
                S_FIR:
                begin
                    // issue one tap read a cycle, accumulate the one before
                    if (rd_cnt_reg != HPTR_W'(FIR_TAPS))
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                        coef_k_reg <= rd_cnt_reg;
                        pv_reg     <= 1'b1;
                        hidx_reg   <= (hidx_reg + 1'b1 >= HPTR_W'(FIR_TAPS))
                                      ? '0 : hidx_reg + 1'b1;
                    end
                    else
                        pv_reg <= 1'b0;
                    if (pv_reg)
                        acc_reg <= acc_reg
                                   + ACC_W'(H_ROM[HPTR_W'(FIR_TAPS - 1) - coef_k_reg]
                                            * hist_q_reg);
                end
                S_G1:
                begin
                    gp_lo_reg <= 30'(usb[17:0]) * 30'(gain_reg);
                    gp_hi_reg <= 35'($signed(usb[ACC_W-1:18]) * $signed({1'b0, gain_reg}));
                end
                S_G2:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= audio;
                        m_user_reg   <= ch_reg;
                        m_last_reg   <= last_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // history memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            hist_mem[HIST_AW'(clr_cnt_reg)] <= '0;
        else if (state_reg == S_WR)
            hist_mem[hbase + HIST_AW'(h_cur)] <= mim_reg;
        if (state_reg == S_FIR && rd_cnt_reg != HPTR_W'(FIR_TAPS))
            hist_q_reg <= hist_mem[hbase + HIST_AW'(hidx_reg)];
    end

    // delay memory: write current slot, read the oldest
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            if (32'(clr_cnt_reg) < 32'(DELAY_DEPTH))
                delay_mem[DELAY_AW'(clr_cnt_reg)] <= '0;
        end
        else if (state_reg == S_WR)
            delay_mem[dbase + DELAY_AW'(d_cur)] <= mre_reg;
        if (state_reg == S_WR)
            dly_q_reg <= delay_mem[dbase + DELAY_AW'(d_nxt)];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // no new beat right after one is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // no input while memories are being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s_tready)
        else $error("input ready during clearing pass");

    // tap counter stays in range
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= HPTR_W'(FIR_TAPS))
        else $error("tap counter overran");

    // a result is only loaded from the gain stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_G2)
        else $error("output beat from wrong state");
`endif

endmodule

[test/hud_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hud_checker
// watches the sample, audio and register ports of the usb demodulator,
// predicts every audio beat from its own mixer, delay line and hilbert fir,
// and compares each output beat field by field in arrival order
// ----------------------------------------------------------------------------
module hud_checker
    import hud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [4:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [4:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fails,
    output int          pending
);

    localparam int         DLY            = (FIR_TAPS - 1) / 2 + 1;

    typedef struct packed {
        logic [4:0]         chan;
        logic signed [15:0] audio;
        logic               last;
    } audio_beat_t;

    audio_beat_t audio_q[$];

    longint      sine_quarter [0:QUARTER];
    longint      hil_coef [0:FIR_TAPS-1];
    logic [31:0] step_reg;
    logic [11:0] gain_reg;
    longint      q_hist [0:CHAN_COUNT-1][0:FIR_TAPS-1];
    int          q_wr [0:CHAN_COUNT-1];
    longint      i_line [0:CHAN_COUNT-1][0:DLY-1];
    int          i_wr [0:CHAN_COUNT-1];
    logic [31:0] nco [0:CHAN_COUNT-1];

    // integer square root by bit pairs
    function automatic longint unsigned int_sqrt(longint unsigned val);
        longint unsigned rem, root, b;
        rem  = val;
        root = 0;
        b    = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // tables: taylor quarter sine rounded to q15 and unit energy hilbert taps
    initial
    begin
        longint unsigned x, x2, t, s, sq, ak, den, num;
        longint          acc, v;
        int              k;
        for (int r = 0; r <= QUARTER; r++)
        begin
            x   = (64'd1686629713 * 64'(r)) >> (SINE_TABLE_BITS - 2);
            x2  = (x * x) >> 30;
            t   = x;
            acc = longint'(x);
            for (int n = 1; n <= 12; n++)
            begin
                t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
            end
            if (acc < 0)
                acc = 0;
            v = longint'((64'(acc) + 64'd16384) >> 15);
            sine_quarter[r] = (v > 32767) ? 32767 : v;
        end
        s = 0;
        for (int j = 0; j < FIR_TAPS; j++)
        begin
            k  = j - FIR_TAPS / 2;
            ak = 64'(k < 0 ? -k : k);
            if (ak[0])
                s = s + (64'd1 << 60) / (ak * ak);
        end
        sq  = int_sqrt(s);
        num = 64'd1 << (COEF_BITS - 1 + 30);
        for (int j = 0; j < FIR_TAPS; j++)
        begin
            k  = j - FIR_TAPS / 2;
            ak = 64'(k < 0 ? -k : k);
            hil_coef[j] = 0;
            if (ak[0] && sq != 0)
            begin
                den = ak * sq;
                hil_coef[j] = longint'((num + den / 2) / den);
                if (k < 0)
                    hil_coef[j] = -hil_coef[j];
            end
        end
    end

    function automatic longint wave_at(logic [SINE_TABLE_BITS-1:0] p);
        logic [1:0] quad;
        int         r;
        longint     v;
        quad = p[SINE_TABLE_BITS-1 -: 2];
        r    = int'(p[SINE_TABLE_BITS-3:0]);
        v    = quad[0] ? sine_quarter[QUARTER - r] : sine_quarter[r];
        return quad[1] ? -v : v;
    endfunction

    function automatic longint clip_sample(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    // one sample through mixer, delay line and fir, updating channel state
    function automatic logic signed [15:0] demod_sample(int ch, longint re, longint im);
        logic [SINE_TABLE_BITS-1:0] p;
        longint                     sn, cs, nr, ni, delayed, fir, usb, prod;
        longint unsigned            mag;
        int                         idx;
        if (step_reg != 0)
        begin
            p  = nco[ch][31 -: SINE_TABLE_BITS];
            sn = wave_at(p);
            cs = wave_at(p + SINE_TABLE_BITS'(QUARTER));
            nr = (re * cs - im * sn + 16384) >>> 15;
            ni = (re * sn + im * cs + 16384) >>> 15;
            re = nr;
            im = ni;
            nco[ch] = nco[ch] + step_reg;
        end
        re = clip_sample(re);
        im = clip_sample(im);
        i_line[ch][i_wr[ch]] = re;
        i_wr[ch] = (i_wr[ch] + 1 >= DLY) ? 0 : i_wr[ch] + 1;
        delayed = i_line[ch][i_wr[ch]];
        q_hist[ch][q_wr[ch]] = im;
        q_wr[ch] = (q_wr[ch] + 1 >= FIR_TAPS) ? 0 : q_wr[ch] + 1;
        idx = q_wr[ch];
        fir = 0;
        for (int i = 0; i < FIR_TAPS; i++)
        begin
            fir = fir + hil_coef[FIR_TAPS - 1 - i] * q_hist[ch][idx];
            idx = (idx + 1 >= FIR_TAPS) ? 0 : idx + 1;
        end
        usb  = delayed * (longint'(1) << (COEF_BITS - 1)) - fir;
        prod = usb * longint'(gain_reg);
        mag  = prod < 0 ? 64'(-prod) : 64'(prod);
        mag  = mag >> (COEF_BITS + 7);
        if (prod < 0)
            return (mag > 32768) ? -16'sd32768 : 16'(-longint'(mag));
        return (mag > 32767) ? 16'sd32767 : 16'(mag);
    endfunction

    // state after reset, register writes, input beats and output beats
    always @(posedge clk)
    begin
        audio_beat_t exp_b;
        if (!rst_n)
        begin
            fails    <= 0;
            pending  <= 0;
            step_reg <= '0;
            gain_reg <= 12'd1280;
            audio_q.delete();
            for (int c = 0; c < CHAN_COUNT; c++)
            begin
                q_wr[c] = 0;
                i_wr[c] = 0;
                nco[c]  = '0;
                for (int j = 0; j < FIR_TAPS; j++)
                    q_hist[c][j] = 0;
                for (int j = 0; j < DLY; j++)
                    i_line[c][j] = 0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PHASE_STEP)
                    step_reg <= cfg_data;
                else if (cfg_index == REG_GAIN)
                    gain_reg <= cfg_data[11:0];
            end
            if (s_tvalid && s_tready)
            begin
                exp_b.chan  = s_tuser;
                exp_b.last  = s_tlast;
                exp_b.audio = demod_sample(int'(s_tuser),
                                           longint'($signed(s_tdata[15:0])),
                                           longint'($signed(s_tdata[31:16])));
                audio_q.push_back(exp_b);
            end
            if (m_tvalid && m_tready)
            begin
                if (audio_q.size() == 0)
                begin
                    $display("%0t: unexpected audio beat chan %0d audio %0d last %0b",
                             $time, m_tuser, $signed(m_tdata), m_tlast);
                    fails <= fails + 1;
                end
                else
                begin
                    exp_b = audio_q.pop_front();
                    if (exp_b.chan !== m_tuser || exp_b.audio !== m_tdata
                        || exp_b.last !== m_tlast)
                    begin
                        $display("%0t: exp ch %0d au %0d l %0b, got ch %0d au %0d l %0b",
                                 $time, exp_b.chan, exp_b.audio, exp_b.last,
                                 m_tuser, $signed(m_tdata), m_tlast);
                        fails <= fails + 1;
                    end
                end
            end
            pending <= audio_q.size();
        end
    end

endmodule

[test/tb_hilbert_usb_demodulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hilbert_usb_demodulator
// drives samples through several phase step and gain settings, with random
// idling on both sides; the checker predicts and compares every audio beat
// ----------------------------------------------------------------------------
module tb_hilbert_usb_demodulator
    import hud_pkg::*;
;

    localparam int         CYCLE_LIMIT    = 2000000;
    localparam int         DRAIN_CYCLES   = 200;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [4:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fails;
    int          pending;
    bit          idle_on;
    int          stall_left;
    int          cycles;

    hilbert_usb_demodulator u_top (.*);

    hud_checker u_chk (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // audio side back pressure in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            m_tready   <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 12) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_sample(logic [4:0] ch, logic [15:0] i_s, logic [15:0] q_s, logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {q_s, i_s};
        s_tuser  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // wait for every audio beat, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(logic [31:0] step, logic [11:0] gain);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PHASE_STEP;
        cfg_data  <= step;
        @(posedge clk);
        cfg_index <= REG_GAIN;
        cfg_data  <= {20'd0, gain};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random samples, mostly on a few channels so the filters fill up
    task automatic random_run(int count);
        logic [4:0]  ch;
        logic [15:0] i_s, q_s;
        for (int n = 0; n < count; n++)
        begin
            ch  = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 2)) : 5'($urandom);
            i_s = 16'($urandom);
            q_s = 16'($urandom);
            if ($urandom_range(0, 9) == 0)
                i_s = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            if ($urandom_range(0, 9) == 0)
                q_s = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            if ($urandom_range(0, 3) == 0)
            begin
                i_s = 16'($signed(i_s) >>> 6);
                q_s = 16'($signed(q_s) >>> 6);
            end
            send_sample(ch, i_s, q_s, $urandom_range(0, 7) == 0);
        end
    endtask

    // stimulus
    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_tlast    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_PHASE_STEP;
        cfg_data   = '0;
        idle_on    = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset gain, bypass, field extremes
        send_sample(5'd0, 16'h7fff, 16'h7fff, 1'b0);
        send_sample(5'd0, 16'h8000, 16'h8000, 1'b1);
        send_sample(5'd31, 16'h7fff, 16'h8000, 1'b0);
        send_sample(5'd31, 16'h8000, 16'h7fff, 1'b1);
        send_sample(5'd1, 16'h0000, 16'h0000, 1'b0);
        send_sample(5'd1, 16'hffff, 16'h0001, 1'b0);
        for (int n = 0; n < 8; n++)
            send_sample(5'd2, 16'h7fff, (n % 2) ? 16'h7fff : 16'h8000, n == 7);
        drain();

        // directed: top gain and full scale mixing
        set_regs(32'hffffffff, 12'd4095);
        for (int n = 0; n < 6; n++)
            send_sample(5'd3, 16'h8000, 16'h8000, n == 5);
        send_sample(5'd4, 16'h7fff, 16'h7fff, 1'b1);
        drain();
        set_regs(32'h40000000, 12'd0);
        for (int n = 0; n < 4; n++)
            send_sample(5'd5, 16'h7fff, 16'h8000, 1'b0);
        drain();

        // random phases over several settings
        set_regs(32'd0, 12'd1280);
        random_run(200);
        drain();
        set_regs(32'h01000000, 12'd4095);
        random_run(200);
        drain();
        set_regs(32'hffffffff, 12'd256);
        random_run(180);
        drain();
        set_regs($urandom, 12'($urandom));
        random_run(180);
        drain();
        set_regs($urandom, 12'($urandom_range(0, 4095)));
        random_run(120);
        drain();

        // last part with no idling
        idle_on = 1'b0;
        set_regs(32'h00100000, 12'd1280);
        random_run(200);
        drain();

        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
